/* design/slpg_pkg.sv */
package slpg_pkg;

    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_SOLID  = 3'd1,
        MODE_LISTEN = 3'd2,
        MODE_RECORD = 3'd3,
        MODE_LOWBAT = 3'd4,
        MODE_UPLOAD = 3'd5,
        MODE_ERROR  = 3'd6,
        MODE_UNUSED = 3'd7
    } t_mode;

    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_BRIGHTNESS = 3'd1;
    localparam logic [2:0] REG_LISTEN     = 3'd2;
    localparam logic [2:0] REG_RECORD     = 3'd3;
    localparam logic [2:0] REG_LOWBAT     = 3'd4;
    localparam logic [2:0] REG_UPLOAD     = 3'd5;
    localparam logic [2:0] REG_ERRPAT     = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // sine table steps per turn; power of two, the phase math relies on it
    localparam int SINE_STEPS = 256;
    localparam int SINE_W     = $clog2(SINE_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_DIV,
        ST_SINE,
        ST_EVAL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start_mod;
        logic start_div;
        logic start_sine;
        logic eval;
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic div_done;
        logic sine_done;
    } t_status;

    typedef struct packed {
        logic [7:0] led_level;
        logic       level_is_pwm;
        logic       write_strobe;
    } t_result;

    function automatic logic [2:0] letter_len(input logic [3:0] l);
        case (l) inside
            4'd1, 4'd3, 4'd4, 4'd5, 4'd7: letter_len = 3'd3;
            4'd2: letter_len = 3'd2;
            4'd6: letter_len = 3'd4;
            default: letter_len = 3'd1;
        endcase
    endfunction

    function automatic logic [3:0] letter_dash(input logic [3:0] l);
        case (l) inside
            4'd2, 4'd4: letter_dash = 4'h2;
            4'd3: letter_dash = 4'h6;
            4'd5: letter_dash = 4'h4;
            4'd6, 4'd7: letter_dash = 4'h1;
            default: letter_dash = 4'h0;
        endcase
    endfunction

endpackage

/* design/slpg_if.sv */
interface slpg_if #(
    parameter int W = 1
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/slpg_ctrl.sv */
module slpg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  slpg_pkg::t_status   i_status,
    output slpg_pkg::t_cmd      o_cmd
);
    slpg_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slpg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            slpg_pkg::ST_IDLE: if (i_in_valid) n_state = slpg_pkg::ST_MOD;
            slpg_pkg::ST_MOD:  if (i_status.mod_done) n_state = slpg_pkg::ST_DIV;
            slpg_pkg::ST_DIV:  if (i_status.div_done) n_state = slpg_pkg::ST_SINE;
            slpg_pkg::ST_SINE: if (i_status.sine_done) n_state = slpg_pkg::ST_EVAL;
            slpg_pkg::ST_EVAL: n_state = slpg_pkg::ST_OUT;
            slpg_pkg::ST_OUT:  if (i_out_ready) n_state = slpg_pkg::ST_IDLE;
            default: n_state = slpg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_out_valid      = 1'b0;
        o_cmd            = '0;
        unique case (r_state)
            slpg_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.start_mod = i_in_valid;
            end
            slpg_pkg::ST_MOD:  o_cmd.start_div = i_status.mod_done;
            slpg_pkg::ST_DIV:  o_cmd.start_sine = i_status.div_done;
            slpg_pkg::ST_SINE: ;
            slpg_pkg::ST_EVAL: o_cmd.eval = 1'b1;
            slpg_pkg::ST_OUT:  o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

/* design/slpg_dp.sv */
module slpg_dp #(
    parameter int DOT_MS  = 200,
    parameter int DASH_MS = 600
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [slpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [slpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_accept,
    input  logic                          i_tick,
    input  slpg_pkg::t_cmd                i_cmd,
    output slpg_pkg::t_status             o_status,
    output slpg_pkg::t_result             o_result
);
    localparam int SW = slpg_pkg::SINE_W;

    logic [2:0]  r_mode;
    logic [7:0]  r_bright;
    logic [15:0] r_listen, r_record, r_lowbat;
    logic [7:0]  r_upload;
    logic [3:0]  r_errpat;

    logic [31:0] r_now, r_last, r_sym_start;
    logic [9:0]  r_ms1000;
    logic        r_blink, r_mrun, r_lit;
    logic [2:0]  r_midx;
    logic [3:0]  r_letter;
    slpg_pkg::t_result r_res, n_res;

    // mod unit: now % period (listen), restoring, 1 bit/cycle
    logic [15:0] r_per;
    logic [31:0] r_mq;
    logic [16:0] r_mrem;
    logic [5:0]  r_mcnt;
    logic        r_mbusy;
    logic [16:0] n_mrem, m_try;

    // div unit: rem * SINE_STEPS / period
    logic [SW+15:0] r_dnum;
    logic [16:0]    r_drem;
    logic [SW-1:0]  r_dq, n_dq;
    logic [4:0]     r_dcnt;
    logic           r_dbusy;
    logic [16:0]    d_sh, d_try;

    // sine: staged multiplies
    logic [2:0]  r_sstep;
    logic [14:0] r_q;
    logic [1:0]  r_quad;
    logic [31:0] r_acc;
    logic [15:0] r_q2, r_inner, r_mid, s_clip;
    logic [15:0] g;

    always_comb begin
        m_try  = {r_mrem[15:0], r_mq[31]};
        n_mrem = (m_try >= {1'b0, r_per}) ? m_try - {1'b0, r_per} : m_try;
        d_sh   = {r_drem[15:0], r_dnum[SW+15]};
        d_try  = (d_sh >= {1'b0, r_per}) ? d_sh - {1'b0, r_per} : d_sh;
        n_dq   = {r_dq[SW-2:0], (d_sh >= {1'b0, r_per})};
        g      = 16'({n_dq, 16'd0} >> SW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_dbusy <= 1'b0;
            r_sstep <= 3'd0;
        end else begin
            if (i_cmd.start_mod) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= 6'd0;
                r_per   <= (r_listen == 16'd0) ? 16'd1 : r_listen;
                r_mq    <= r_now + 32'(i_tick);
                r_mrem  <= '0;
            end else if (r_mbusy) begin
                r_mrem <= n_mrem;
                r_mq   <= {r_mq[30:0], 1'b0};
                r_mcnt <= r_mcnt + 6'd1;
                if (r_mcnt == 6'd31) r_mbusy <= 1'b0;
            end
            if (i_cmd.start_div) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
                r_dnum  <= {n_mrem[15:0], {SW{1'b0}}};
                r_drem  <= '0;
            end else if (r_dbusy) begin
                r_drem <= d_try;
                r_dq   <= n_dq;
                r_dnum <= {r_dnum[SW+14:0], 1'b0};
                r_dcnt <= r_dcnt + 5'd1;
                if (r_dcnt == 5'(SW + 15)) r_dbusy <= 1'b0;
            end
            if (i_cmd.start_sine) begin
                r_quad  <= g[15:14];
                r_q     <= g[14] ? 15'(16384 - {1'b0, g[13:0]}) : {1'b0, g[13:0]};
                r_sstep <= 3'd1;
            end else if (r_sstep != 3'd0) begin
                r_sstep <= r_sstep + 3'd1;
                case (r_sstep)
                    3'd1: r_acc <= 32'(r_q) * 32'(r_q);
                    3'd2: r_q2 <= 16'(r_acc >> 14);
                    3'd3: r_acc <= 32'(r_q2) * 32'd1192;
                    3'd4: r_inner <= 16'(16'd10544 - 16'(r_acc >> 14));
                    3'd5: r_acc <= 32'(r_q2) * 32'(r_inner);
                    3'd6: begin
                        r_mid <= 16'(16'd25736 - 16'(r_acc >> 14));
                        r_sstep <= 3'd7;
                    end
                    default: begin
                        r_sstep <= 3'd0;
                    end
                endcase
            end
        end
    end

    // final q*mid product registered in status stage; brightness product is combinational
    logic [31:0] r_qm;
    logic        r_qm_ok;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_qm_ok <= 1'b0;
        else begin
            r_qm_ok <= (r_sstep == 3'd7);
            if (r_sstep == 3'd7) r_qm <= 32'(r_q) * 32'(r_mid);
        end
    end

    assign o_status.mod_done  = r_mbusy && (r_mcnt == 6'd31);
    assign o_status.div_done  = r_dbusy && (r_dcnt == 5'(SW + 15));
    assign o_status.sine_done = r_qm_ok;

    logic [31:0] s_raw, dt, dsym;
    logic [15:0] inten;
    logic [23:0] duty;
    logic [15:0] bper;
    logic        on;
    logic [3:0]  dash_mask;
    logic [15:0] dur;
    always_comb begin
        s_raw     = r_qm >> 14;
        s_clip    = (s_raw > 32'd16384) ? 16'd16384 : s_raw[15:0];
        inten     = (r_quad < 2'd2) ? 16'd16384 + s_clip : 16'd16384 - s_clip;
        duty      = 24'(inten) * 24'(r_bright);
        dt        = r_now - r_last;
        dsym      = r_now - r_sym_start;
        bper      = (r_mode == slpg_pkg::MODE_RECORD) ? r_record :
                    (r_mode == slpg_pkg::MODE_LOWBAT) ? r_lowbat : 16'd100;
        on        = (r_ms1000 < 10'(r_upload)) ||
                    (r_ms1000 >= 10'd200 && r_ms1000 < 10'd200 + 10'(r_upload));
        dash_mask = slpg_pkg::letter_dash(r_letter);
        dur       = dash_mask[r_midx[1:0]] ? 16'(DASH_MS) : 16'(DOT_MS);
    end

    always_comb begin
        n_res = '0;
        if (r_mrun) begin
            if (!r_lit) begin
                n_res.write_strobe = 1'b1;
                if (r_midx < slpg_pkg::letter_len(r_letter)) n_res.led_level = 8'd255;
            end else if (dsym >= 32'(dur)) begin
                n_res.write_strobe = 1'b1;
            end
        end else begin
            unique case (r_mode) inside
                slpg_pkg::MODE_OFF: n_res.write_strobe = 1'b1;
                slpg_pkg::MODE_SOLID: n_res = '{8'd255, 1'b0, 1'b1};
                slpg_pkg::MODE_LISTEN: if (dt > 32'd10) begin
                    n_res = '{duty[22:15], 1'b1, 1'b1};
                end
                slpg_pkg::MODE_UPLOAD: if (dt > 32'd10) begin
                    n_res = '{on ? 8'd255 : 8'd0, 1'b0, 1'b1};
                end
                slpg_pkg::MODE_RECORD, slpg_pkg::MODE_LOWBAT, slpg_pkg::MODE_ERROR: begin
                    if (!(r_mode == slpg_pkg::MODE_ERROR && r_errpat != 4'd0) &&
                        dt >= 32'(bper)) begin
                        n_res = '{r_blink ? 8'd0 : 8'd255, 1'b0, 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0; r_bright <= 8'd255; r_listen <= 16'd2000;
            r_record <= 16'd500; r_lowbat <= 16'd1000; r_upload <= 8'd100;
            r_errpat <= '0;
            r_now <= '0; r_last <= '0; r_sym_start <= '0; r_ms1000 <= '0;
            r_blink <= 1'b0; r_mrun <= 1'b0; r_lit <= 1'b0;
            r_midx <= '0; r_letter <= '0;
            r_res <= '0;
        end else begin
            if (i_in_accept && i_tick) begin
                r_now <= r_now + 32'd1;
                // now % 1000, restarting where the ms counter wraps
                if (r_now == 32'hFFFF_FFFF || r_ms1000 == 10'd999) r_ms1000 <= '0;
                else r_ms1000 <= r_ms1000 + 10'd1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    slpg_pkg::REG_MODE: if (i_cfg_data[2:0] != r_mode) begin
                        r_mode <= i_cfg_data[2:0];
                        r_last <= '0; r_blink <= 1'b0; r_mrun <= 1'b0;
                    end
                    slpg_pkg::REG_BRIGHTNESS: r_bright <= i_cfg_data[7:0];
                    slpg_pkg::REG_LISTEN: r_listen <= i_cfg_data;
                    slpg_pkg::REG_RECORD: r_record <= i_cfg_data;
                    slpg_pkg::REG_LOWBAT: r_lowbat <= i_cfg_data;
                    slpg_pkg::REG_UPLOAD: r_upload <= i_cfg_data[7:0];
                    slpg_pkg::REG_ERRPAT: r_errpat <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.eval) begin
                r_res <= n_res;
                if (r_mrun) begin
                    if (!r_lit) begin
                        if (r_midx >= slpg_pkg::letter_len(r_letter)) begin
                            if (dt > 32'd2000) begin
                                r_midx <= '0; r_last <= r_now;
                            end
                        end else begin
                            r_lit <= 1'b1; r_sym_start <= r_now;
                        end
                    end else if (dsym >= 32'(dur)) begin
                        r_lit <= 1'b0; r_midx <= r_midx + 3'd1; r_last <= r_now;
                    end
                end else begin
                    unique case (r_mode) inside
                        slpg_pkg::MODE_LISTEN, slpg_pkg::MODE_UPLOAD: begin
                            if (dt > 32'd10) r_last <= r_now;
                        end
                        slpg_pkg::MODE_RECORD, slpg_pkg::MODE_LOWBAT,
                        slpg_pkg::MODE_ERROR: begin
                            if (r_mode == slpg_pkg::MODE_ERROR && r_errpat != 4'd0) begin
                                r_mrun <= 1'b1; r_midx <= '0; r_lit <= 1'b0;
                                r_last <= r_now;
                                r_letter <= (r_errpat > 4'd8) ? 4'd8 : r_errpat;
                            end else if (dt >= 32'(bper)) begin
                                r_blink <= ~r_blink; r_last <= r_now;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    assign o_result = r_res;
endmodule

/* design/status_led_pattern_generator.sv */
// Sequence: serial modulo, serial divide, staged sine, then an evaluate state;
// the result is registered there and held valid until the output side takes it.
// Throughput: one transaction at a time; a new one is taken only in idle, after
// the last result was taken; serial modulo, divide and output stalls set the rate.
// Reset: synchronous active low; registers return to defaults, time and state to zero.
module status_led_pattern_generator #(
    parameter int DOT_MS  = 200,
    parameter int DASH_MS = 600
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [slpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    slpg_if.sink                            in_if,
    slpg_if.source                          out_if
);
    slpg_pkg::t_cmd    cmd;
    slpg_pkg::t_status status;
    slpg_pkg::t_result res;
    logic              in_ready;

    assign in_if.ready = in_ready;

    slpg_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_if.valid), .o_in_ready(in_ready),
        .o_out_valid(out_if.valid), .i_out_ready(out_if.ready),
        .i_status(status), .o_cmd(cmd)
    );

    slpg_dp #(.DOT_MS(DOT_MS), .DASH_MS(DASH_MS)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_accept(in_if.valid && in_ready), .i_tick(in_if.data[0]),
        .i_cmd(cmd), .o_status(status), .o_result(res)
    );

    assign out_if.data = {res.led_level, res.level_is_pwm, res.write_strobe};
endmodule

/* design/slpg_checker.sv */
module slpg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [9:0] i_out_data
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready) else $error("input taken while result pending");
    a_quiet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data[0]) |-> (i_out_data[9:1] == 9'd0))
        else $error("quiet nonzero");
    a_pwm_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data[1]) |-> i_out_data[0]) else $error("pwm without strobe");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid) else $error("result dropped");
endmodule

bind status_led_pattern_generator slpg_checker u_chk (
    .i_clk, .i_rst_n,
    .i_in_valid(in_if.valid), .i_in_ready(in_if.ready),
    .i_out_valid(out_if.valid), .i_out_ready(out_if.ready), .i_out_data(out_if.data)
);

/* tb/sv/tb_status_led_pattern_generator.sv */
module tb_status_led_pattern_generator;

    localparam logic [2:0] REG_NONE = 3'd7;
    localparam int STALL_LIMIT = 5000;
    localparam bit [31:0] DOT_MS_V  = 32'd200;
    localparam bit [31:0] DASH_MS_V = 32'd600;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [slpg_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [slpg_pkg::CFG_DATA_W-1:0] cfg_data;

    slpg_if #(.W(1)) tick_if ();
    slpg_if #(.W($bits(slpg_pkg::t_result))) led_if ();

    status_led_pattern_generator i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .in_if     (tick_if.sink),
        .out_if    (led_if.source)
    );

    // shadow registers
    slpg_pkg::t_mode cur_mode;
    bit [7:0]   cur_bright;
    bit [15:0]  per_listen, per_record, per_lowbat;
    bit [7:0]   flash_on;
    bit [3:0]   err_pat;
    // shadow pattern state
    bit [31:0]  ms_count, last_write_ms, sym_start_ms;
    bit         blink_on, morse_on, sym_lit;
    bit [2:0]   sym_idx;
    bit [3:0]   latched_letter;

    bit [2:0] morse_len [9] = '{3'd1, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd1};
    bit [3:0] morse_dash [9] = '{4'h0, 4'h0, 4'h2, 4'h6, 4'h2, 4'h4, 4'h1, 4'h1, 4'h0};

    bit                pending_ticks [$];
    slpg_pkg::t_result expected_led [$];
    int        errors, n_in, n_out, n_writes, n_pwm, n_morse;
    int        src_gap, sink_gap, hold_cnt, idle_cyc;
    bit        calm, held;

    function automatic slpg_pkg::t_result drive(input bit [7:0] lvl, input bit pwm);
        slpg_pkg::t_result r;
        r.led_level    = lvl;
        r.level_is_pwm = pwm;
        r.write_strobe = 1'b1;
        return r;
    endfunction

    function automatic bit [31:0] quarter_wave(input bit [31:0] q);
        bit [31:0] q2, inner, mid, s;
        q2    = (q * q) >> 14;
        inner = 32'd10544 - ((q2 * 32'd1192) >> 14);
        mid   = 32'd25736 - ((q2 * inner) >> 14);
        s     = (q * mid) >> 14;
        return (s > 32'd16384) ? 32'd16384 : s;
    endfunction

    function automatic slpg_pkg::t_result blink_step(input bit [31:0] period);
        bit [31:0]         d;
        slpg_pkg::t_result r;
        r = '0;
        d = ms_count - last_write_ms;
        if (d >= period) begin
            blink_on      = !blink_on;
            last_write_ms = ms_count;
            r = drive(blink_on ? 8'd255 : 8'd0, 1'b0);
        end
        return r;
    endfunction

    function automatic slpg_pkg::t_result predict_led(input bit tick);
        slpg_pkg::t_result r;
        bit [31:0] d, per, c, q, s, inten, dur;
        bit [63:0] p, g;
        bit [1:0]  quad;
        bit        on;
        r = '0;
        if (tick) ms_count = ms_count + 1;
        d = ms_count - last_write_ms;
        if (morse_on) begin
            if (!sym_lit) begin
                if (sym_idx >= morse_len[latched_letter]) begin
                    if (d > 32'd2000) begin
                        sym_idx       = '0;
                        last_write_ms = ms_count;
                    end
                    r = drive(8'd0, 1'b0);
                end else begin
                    sym_lit      = 1'b1;
                    sym_start_ms = ms_count;
                    r = drive(8'd255, 1'b0);
                end
            end else begin
                dur = morse_dash[latched_letter][sym_idx[1:0]] ? DASH_MS_V : DOT_MS_V;
                if (ms_count - sym_start_ms >= dur) begin
                    sym_lit       = 1'b0;
                    sym_idx       = sym_idx + 1;
                    last_write_ms = ms_count;
                    r = drive(8'd0, 1'b0);
                end
            end
            return r;
        end
        case (cur_mode)
            slpg_pkg::MODE_OFF:    r = drive(8'd0, 1'b0);
            slpg_pkg::MODE_SOLID:  r = drive(8'd255, 1'b0);
            slpg_pkg::MODE_LISTEN: begin
                per  = (per_listen == 0) ? 32'd1 : 32'(per_listen);
                p    = (64'(ms_count % per) * 64'd256) / 64'(per);
                g    = ((p * 64'd65536) / 64'd256) & 64'hFFFF;
                quad = g[15:14];
                q    = quad[0] ? 32'd16384 - 32'(g[13:0]) : 32'(g[13:0]);
                s    = quarter_wave(q);
                inten = (quad < 2) ? 32'd16384 + s : 32'd16384 - s;
                if (d > 32'd10) begin
                    last_write_ms = ms_count;
                    r = drive(8'((inten * cur_bright) >> 15), 1'b1);
                end
            end
            slpg_pkg::MODE_RECORD: r = blink_step(32'(per_record));
            slpg_pkg::MODE_LOWBAT: r = blink_step(32'(per_lowbat));
            slpg_pkg::MODE_UPLOAD: begin
                c  = ms_count % 32'd1000;
                on = (c < flash_on) || (c >= 32'd200 && c < 32'd200 + flash_on);
                if (d > 32'd10) begin
                    last_write_ms = ms_count;
                    r = drive(on ? 8'd255 : 8'd0, 1'b0);
                end
            end
            slpg_pkg::MODE_ERROR: begin
                if (err_pat != 0) begin
                    morse_on       = 1'b1;
                    sym_idx        = '0;
                    sym_lit        = 1'b0;
                    last_write_ms  = ms_count;
                    latched_letter = (err_pat > 8) ? 4'd8 : err_pat;
                    n_morse++;
                end else begin
                    r = blink_step(32'd100);
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        n_writes++;
        case (idx)
            slpg_pkg::REG_MODE: begin
                if (val[2:0] != cur_mode) begin
                    cur_mode      = slpg_pkg::t_mode'(val[2:0]);
                    last_write_ms = '0;
                    blink_on      = 1'b0;
                    morse_on      = 1'b0;
                end
            end
            slpg_pkg::REG_BRIGHTNESS: cur_bright = val[7:0];
            slpg_pkg::REG_LISTEN:     per_listen = val;
            slpg_pkg::REG_RECORD:     per_record = val;
            slpg_pkg::REG_LOWBAT:     per_lowbat = val;
            slpg_pkg::REG_UPLOAD:     flash_on   = val[7:0];
            slpg_pkg::REG_ERRPAT:     err_pat    = val[3:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_ticks.size() == 0);
        @(posedge i_clk);
        wait (!tick_if.valid && expected_led.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic run_ticks(input int n);
        for (int k = 0; k < n; k++)
            pending_ticks.push_back($urandom_range(0, 7) != 0);
        drain();
    endtask

    task automatic directed(input bit [3:0] pat);
        for (int k = 0; k < 4; k++)
            pending_ticks.push_back(pat[k]);
        drain();
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        tick_if.valid   = 1'b0;
        tick_if.data    = '0;
        led_if.ready    = 1'b0;
        forever #4 i_clk = !i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                expected_led.push_back(predict_led(tick_if.data[0]));
                n_in++;
            end
            if (!tick_if.valid || tick_if.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    tick_if.valid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    tick_if.data  <= pending_ticks.pop_front();
                    tick_if.valid <= 1'b1;
                    if (!calm && $urandom_range(0, 15) == 0)
                        src_gap = $urandom_range(1, 15);
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        slpg_pkg::t_result got, want;
        if (!i_rst_n) begin
            led_if.ready <= 1'b0;
        end else begin
            if (led_if.valid && led_if.ready) begin
                got = slpg_pkg::t_result'(led_if.data);
                n_out++;
                if (got.level_is_pwm) n_pwm++;
                if (expected_led.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %h", $time, got);
                    errors++;
                end else begin
                    want = expected_led.pop_front();
                    if (got.led_level !== want.led_level) begin
                        $display("%0t: led_level expected %0d actual %0d",
                                 $time, want.led_level, got.led_level);
                        errors++;
                    end
                    if (got.level_is_pwm !== want.level_is_pwm) begin
                        $display("%0t: level_is_pwm expected %0d actual %0d",
                                 $time, want.level_is_pwm, got.level_is_pwm);
                        errors++;
                    end
                    if (got.write_strobe !== want.write_strobe) begin
                        $display("%0t: write_strobe expected %0d actual %0d",
                                 $time, want.write_strobe, got.write_strobe);
                        errors++;
                    end
                end
            end
            if (n_out >= 300 && !held) begin
                held     = 1'b1;
                hold_cnt = 600;
            end
            if (calm) begin
                led_if.ready <= 1'b1;
            end else if (hold_cnt > 0) begin
                hold_cnt--;
                led_if.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                led_if.ready <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
                sink_gap = $urandom_range(1, 15) - 1;
                led_if.ready <= 1'b0;
            end else begin
                led_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((tick_if.valid && tick_if.ready) || (led_if.valid && led_if.ready))
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cyc);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        cur_mode   = slpg_pkg::MODE_OFF;
        cur_bright = 8'd255;
        per_listen = 16'd2000;
        per_record = 16'd500;
        per_lowbat = 16'd1000;
        flash_on   = 8'd100;
        err_pat    = 4'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        directed(4'b0110);
        write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_SOLID));
        directed(4'b1001);
        write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_UNUSED));
        directed(4'b1101);
        write_reg(REG_NONE, 16'hFFFF);
        write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_ERROR));
        directed(4'b1111);
        write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_ERROR));
        directed(4'b0011);

        write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_LISTEN));
        write_reg(slpg_pkg::REG_LISTEN, 16'd0);
        write_reg(slpg_pkg::REG_BRIGHTNESS, 16'd0);
        run_ticks(60);
        write_reg(slpg_pkg::REG_LISTEN, 16'hFFFF);
        write_reg(slpg_pkg::REG_BRIGHTNESS, 16'h00FF);
        run_ticks(80);
        write_reg(slpg_pkg::REG_LISTEN, 16'($urandom_range(1, 300)));
        write_reg(slpg_pkg::REG_BRIGHTNESS, 16'($urandom_range(0, 255)));
        run_ticks(150);

        write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_RECORD));
        write_reg(slpg_pkg::REG_RECORD, 16'd0);
        run_ticks(30);
        write_reg(slpg_pkg::REG_RECORD, 16'($urandom_range(1, 50)));
        run_ticks(100);
        write_reg(slpg_pkg::REG_RECORD, 16'hFFFF);
        run_ticks(20);
        write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_LOWBAT));
        write_reg(slpg_pkg::REG_LOWBAT, 16'hFFFF);
        run_ticks(20);
        write_reg(slpg_pkg::REG_LOWBAT, 16'($urandom_range(1, 40)));
        run_ticks(80);

        write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_UPLOAD));
        write_reg(slpg_pkg::REG_UPLOAD, 16'd0);
        run_ticks(40);
        write_reg(slpg_pkg::REG_UPLOAD, 16'd200);
        run_ticks(60);
        write_reg(slpg_pkg::REG_UPLOAD, 16'($urandom_range(0, 200)));
        run_ticks(250);

        write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_OFF));
        write_reg(slpg_pkg::REG_ERRPAT, 16'd0);
        write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_ERROR));
        run_ticks(60);
        write_reg(slpg_pkg::REG_ERRPAT, 16'd8);
        run_ticks(250);
        for (int l = 1; l <= 7; l++) begin
            write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_OFF));
            write_reg(slpg_pkg::REG_ERRPAT, 16'(l));
            write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_ERROR));
            run_ticks(35);
            // letter stays latched while running
            write_reg(slpg_pkg::REG_ERRPAT, 16'($urandom_range(0, 15)));
            write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_ERROR));
            run_ticks(10);
        end
        write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_OFF));
        write_reg(slpg_pkg::REG_ERRPAT, 16'd15);
        write_reg(slpg_pkg::REG_MODE, 16'(slpg_pkg::MODE_ERROR));
        run_ticks(50);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 5) calm = 1'b1;
            write_reg(slpg_pkg::REG_BRIGHTNESS, 16'($urandom_range(0, 255)));
            write_reg(slpg_pkg::REG_LISTEN, 16'($urandom_range(0, 511)));
            write_reg(slpg_pkg::REG_RECORD, 16'($urandom_range(0, 30)));
            write_reg(slpg_pkg::REG_LOWBAT, 16'($urandom_range(0, 30)));
            write_reg(slpg_pkg::REG_UPLOAD, 16'($urandom_range(0, 200)));
            write_reg(slpg_pkg::REG_ERRPAT, 16'($urandom_range(0, 15)));
            write_reg(slpg_pkg::REG_MODE, 16'($urandom_range(0, 7)));
            run_ticks(30);
        end

        $display("Covered all modes and registers: %0d ticks, %0d results, %0d pwm writes,",
                 n_in, n_out, n_pwm);
        $display("%0d register writes and %0d Morse starts.", n_writes, n_morse);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
